// File: rtl/rabs_pkg.sv
// Shared widths, defaults, register indexes and lane control types for the background subtractor.
package rabs_pkg;

    // Fixed field widths.
    localparam int CHAN_W  = 8;
    localparam int ALPHA_W = 16;
    localparam int FRAME_W = 20;
    localparam int NUM_CH  = 3;

    // Configuration port.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = FRAME_W;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_PIXELS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA_Q16    = 1'd1;

    // Register reset values.
    localparam int FRAME_PIXELS_RESET = 307200;
    localparam int ALPHA_Q16_RESET    = 655;

    // Defaults for the top-level parameters.
    localparam int MAX_PIXELS_DEF   = 524288;
    localparam int BG_FRAC_BITS_DEF = 8;

    // Control that every lane receives from the pipeline controller.
    typedef struct packed {
        logic adv;    // pipeline moves on at this edge
        logic fresh;  // entry in stage one has never been written, reads as zero
        logic fwd;    // take the background from the stage-four register
    } lane_ctl_t;

endpackage

// File: rtl/rabs_if.sv
// Stream interfaces for pixel words in and result words out.
interface rabs_pix_if;
    import rabs_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAN_W-1:0] chan0;
    logic [CHAN_W-1:0] chan1;
    logic [CHAN_W-1:0] chan2;

    modport source (output valid, output chan0, output chan1, output chan2, input ready);
    modport sink   (input valid, input chan0, input chan1, input chan2, output ready);
endinterface

interface rabs_res_if;
    import rabs_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAN_W-1:0] bg0;
    logic [CHAN_W-1:0] bg1;
    logic [CHAN_W-1:0] bg2;
    logic [CHAN_W-1:0] diff0;
    logic [CHAN_W-1:0] diff1;
    logic [CHAN_W-1:0] diff2;
    logic [CHAN_W-1:0] inv0;
    logic [CHAN_W-1:0] inv1;
    logic [CHAN_W-1:0] inv2;
    logic              frame_end;

    modport source (output valid, output bg0, output bg1, output bg2,
                    output diff0, output diff1, output diff2,
                    output inv0, output inv1, output inv2,
                    output frame_end, input ready);
    modport sink   (input valid, input bg0, input bg1, input bg2,
                    input diff0, input diff1, input diff2,
                    input inv0, input inv1, input inv2,
                    input frame_end, output ready);
endinterface

// File: rtl/rabs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rabs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/rabs_lane.sv
// One colour channel: background update, difference and inversion over four stages.
module rabs_lane
    import rabs_pkg::*;
#(
    parameter int FRAC_BITS = BG_FRAC_BITS_DEF,
    parameter int BW        = CHAN_W + FRAC_BITS
) (
    input  logic               clk,
    input  lane_ctl_t          ctl,
    input  logic [ALPHA_W-1:0] alpha,
    input  logic [CHAN_W-1:0]  pix_in,
    input  logic [BW-1:0]      rd_bg,
    output logic [BW-1:0]      wr_bg,
    output logic [CHAN_W-1:0]  bg_out,
    output logic [CHAN_W-1:0]  diff_out,
    output logic [CHAN_W-1:0]  inv_out
);

    localparam int PW = ALPHA_W + BW;
    localparam logic [BW:0] HALF_LSB = (BW+1)'(1) << (FRAC_BITS - 1);
    localparam logic [PW:0] STEP_HALF = (PW+1)'(1) << (ALPHA_W - 1);
    localparam logic [CHAN_W-1:0] CHAN_MAX = '1;

    // Stage one: pixel sample.
    logic [CHAN_W-1:0] pix_s1_reg;
    // Stage two: operands of the multiply.
    logic [BW-1:0]     p_s2_reg, b_s2_reg, mag_s2_reg;
    logic              up_s2_reg;
    // Stage three: product.
    logic [PW-1:0]     prod_s3_reg;
    logic [BW-1:0]     p_s3_reg, b_s3_reg;
    logic              up_s3_reg;
    // Stage four: updated background.
    logic [BW-1:0]     nb_s4_reg, p_s4_reg;

    logic [BW-1:0] p_s1, b_s1, mag_s1;
    logic          up_s1;
    logic [PW:0]   prod_rnd;
    logic [BW-1:0] step_s3, nb_s3;
    logic [BW-1:0] d_s4;
    logic [BW:0]   bg_sum, diff_sum;
    logic [BW-FRAC_BITS:0] bg_q, diff_q;

    // Stage one: choose the old background and take the distance to the pixel.
    always_comb
    begin
        p_s1 = {pix_s1_reg, {FRAC_BITS{1'b0}}};
        if (ctl.fresh)
        begin
            b_s1 = '0;
        end
        else if (ctl.fwd)
        begin
            b_s1 = nb_s4_reg;
        end
        else
        begin
            b_s1 = rd_bg;
        end
        up_s1  = (p_s1 >= b_s1);
        mag_s1 = up_s1 ? (p_s1 - b_s1) : (b_s1 - p_s1);
    end

    // Stage three: round the scaled step and move the background towards the pixel.
    always_comb
    begin
        prod_rnd = (PW+1)'(prod_s3_reg) + STEP_HALF;
        step_s3  = prod_rnd[ALPHA_W +: BW];
        nb_s3    = up_s3_reg ? (b_s3_reg + step_s3) : (b_s3_reg - step_s3);
    end

    assign wr_bg = nb_s3;

    // Pipeline registers, all moving together.
    always_ff @(posedge clk)
    begin
        if (ctl.adv)
        begin
            pix_s1_reg  <= pix_in;
            p_s2_reg    <= p_s1;
            b_s2_reg    <= b_s1;
            mag_s2_reg  <= mag_s1;
            up_s2_reg   <= up_s1;
            prod_s3_reg <= PW'(alpha) * PW'(mag_s2_reg);
            p_s3_reg    <= p_s2_reg;
            b_s3_reg    <= b_s2_reg;
            up_s3_reg   <= up_s2_reg;
            nb_s4_reg   <= nb_s3;
            p_s4_reg    <= p_s3_reg;
        end
    end

    // Stage four: round background and difference to whole sample values.
    always_comb
    begin
        d_s4     = (p_s4_reg >= nb_s4_reg) ? (p_s4_reg - nb_s4_reg) : (nb_s4_reg - p_s4_reg);
        bg_sum   = (BW+1)'(nb_s4_reg) + HALF_LSB;
        diff_sum = (BW+1)'(d_s4) + HALF_LSB;
        bg_q     = bg_sum[BW:FRAC_BITS];
        diff_q   = diff_sum[BW:FRAC_BITS];
        bg_out   = bg_q[BW-FRAC_BITS] ? CHAN_MAX : bg_q[CHAN_W-1:0];
        diff_out = diff_q[BW-FRAC_BITS] ? CHAN_MAX : diff_q[CHAN_W-1:0];
        inv_out  = CHAN_MAX - diff_out;
    end

endmodule

// File: rtl/running_average_background_subtract.sv
// Running-average background subtractor for three-channel 8-bit pixels.
//
// Pixel words arrive on the pix channel in raster order, one result word leaves on res
// for every pixel: rounded background, absolute difference and its inverse per channel,
// plus a flag on the last pixel of each frame. Registers are written through the cfg
// port (index 0 frame size, index 1 alpha in Q16); the user must write them only while the
// block is idle, which the block itself does not enforce. A result word is offered once
// its pixel has passed through the stage-one to stage-four registers.
// Throughput is one pixel per cycle for frames of three or more pixels while the receiver
// does not stall; it is set by the read-modify-write loop on the background RAM, whose
// update takes three stages, so in a frame of one or two pixels a new pixel is held back
// until the older pixel at its position has left stage two.
// The background RAM holds MAX_PIXELS entries of three (8 + BG_FRAC_BITS)-bit samples.
// After reset a fill count marks every entry as zero until it is first written, so no
// clearing pass is run and pixels are accepted from the first cycle. Reset also sets
// the position to zero and the registers to their defaults.
// When the receiver stalls the whole pipeline holds and pix.ready falls; a word already
// in flight is kept until it is taken.
module running_average_background_subtract
    import rabs_pkg::*;
#(
    parameter int MAX_PIXELS   = MAX_PIXELS_DEF,
    parameter int BG_FRAC_BITS = BG_FRAC_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    rabs_pix_if.sink              pix,
    rabs_res_if.source            res,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int BW = CHAN_W + BG_FRAC_BITS;
    localparam int AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
    localparam int CW = $clog2(MAX_PIXELS + 1);
    localparam int EW = (CW > FRAME_W) ? CW : FRAME_W;
    localparam int EFF_RESET =
        (FRAME_PIXELS_RESET > MAX_PIXELS) ? MAX_PIXELS : FRAME_PIXELS_RESET;

    // Configuration and position state.
    logic [CW-1:0]      eff_reg;
    logic [ALPHA_W-1:0] alpha_reg;
    logic [AW-1:0]      pos_reg;
    logic [CW-1:0]      fill_reg;

    // Pipeline control.
    logic          v1_reg, v2_reg, v3_reg, v4_reg;
    logic [AW-1:0] addr1_reg, addr2_reg, addr3_reg, addr4_reg;
    logic          last1_reg, last2_reg, last3_reg, last4_reg;
    logic          fresh1_reg;

    logic          adv, hazard, acc;
    logic [CW-1:0] pos_inc;
    logic          last_now, fresh_now;
    logic [AW-1:0] pos_next;
    logic [EW-1:0] cfg_ext;
    logic [CW-1:0] eff_next;
    lane_ctl_t     ctl;

    logic [CHAN_W-1:0]   chan_in  [NUM_CH];
    logic [CHAN_W-1:0]   bg_o     [NUM_CH];
    logic [CHAN_W-1:0]   diff_o   [NUM_CH];
    logic [CHAN_W-1:0]   inv_o    [NUM_CH];
    logic [NUM_CH*BW-1:0] rd_word, wr_word;

    // Handshake: hold everything while a finished word waits, and keep a new pixel out
    // while an older pixel at the same position has not yet produced its background.
    assign adv    = !v4_reg || res.ready;
    assign hazard = (v1_reg && (addr1_reg == pos_reg)) || (v2_reg && (addr2_reg == pos_reg));
    assign pix.ready = adv && !hazard;
    assign acc       = pix.valid && pix.ready;

    // Frame position, end-of-frame flag and fill count.
    always_comb
    begin
        pos_inc   = CW'(pos_reg) + CW'(1);
        last_now  = (pos_inc >= eff_reg);
        pos_next  = last_now ? '0 : pos_inc[AW-1:0];
        fresh_now = (CW'(pos_reg) >= fill_reg);
    end

    // Frame size as used: zero counts as one, and it never exceeds the store.
    always_comb
    begin
        cfg_ext = EW'(cfg_data);
        if (cfg_ext == '0)
        begin
            eff_next = CW'(1);
        end
        else if (cfg_ext > EW'(MAX_PIXELS))
        begin
            eff_next = CW'(MAX_PIXELS);
        end
        else
        begin
            eff_next = cfg_ext[CW-1:0];
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eff_reg   <= CW'(EFF_RESET);
            alpha_reg <= ALPHA_W'(ALPHA_Q16_RESET);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FRAME_PIXELS: eff_reg   <= eff_next;
                REG_ALPHA_Q16:    alpha_reg <= cfg_data[ALPHA_W-1:0];
                default:          ;
            endcase
        end
    end

    // Position counter and count of entries written since reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            fill_reg <= '0;
        end
        else if (acc)
        begin
            pos_reg <= pos_next;
            if (fresh_now)
            begin
                fill_reg <= pos_inc;
            end
        end
    end

    // Valid bits of the four stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= acc;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // Addresses and flags that travel with each pixel.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            addr1_reg  <= pos_reg;
            addr2_reg  <= addr1_reg;
            addr3_reg  <= addr2_reg;
            addr4_reg  <= addr3_reg;
            last1_reg  <= last_now;
            last2_reg  <= last1_reg;
            last3_reg  <= last2_reg;
            last4_reg  <= last3_reg;
            fresh1_reg <= fresh_now;
        end
    end

    // Lane control: the stage-four word wrote the store at the edge this read was taken.
    always_comb
    begin
        ctl.adv   = adv;
        ctl.fresh = fresh1_reg;
        ctl.fwd   = v4_reg && (addr4_reg == addr1_reg);
    end

    // Background store, all three channels in one word.
    rabs_ram #(
        .WIDTH (NUM_CH * BW),
        .DEPTH (MAX_PIXELS),
        .AW    (AW)
    ) u_bg_ram (
        .clk   (clk),
        .we    (v3_reg && adv),
        .waddr (addr3_reg),
        .wdata (wr_word),
        .re    (acc),
        .raddr (pos_reg),
        .rdata (rd_word)
    );

    assign chan_in[0] = pix.chan0;
    assign chan_in[1] = pix.chan1;
    assign chan_in[2] = pix.chan2;

    // One lane per colour channel.
    for (genvar c = 0; c < NUM_CH; c++)
    begin : g_lane
        rabs_lane #(
            .FRAC_BITS (BG_FRAC_BITS),
            .BW        (BW)
        ) u_lane (
            .clk      (clk),
            .ctl      (ctl),
            .alpha    (alpha_reg),
            .pix_in   (chan_in[c]),
            .rd_bg    (rd_word[c*BW +: BW]),
            .wr_bg    (wr_word[c*BW +: BW]),
            .bg_out   (bg_o[c]),
            .diff_out (diff_o[c]),
            .inv_out  (inv_o[c])
        );
    end

    // Merge the lanes and the frame flag into the result word.
    assign res.valid     = v4_reg;
    assign res.bg0       = bg_o[0];
    assign res.bg1       = bg_o[1];
    assign res.bg2       = bg_o[2];
    assign res.diff0     = diff_o[0];
    assign res.diff1     = diff_o[1];
    assign res.diff2     = diff_o[2];
    assign res.inv0      = inv_o[0];
    assign res.inv1      = inv_o[1];
    assign res.inv2      = inv_o[2];
    assign res.frame_end = last4_reg;

endmodule
